// ===== hdl/pms_pkg.sv =====
`timescale 1ns / 1ps

package pms_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned SEL_W  = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CFG_W  = 6;

  // one fill counter per selectable stack number
  localparam int unsigned NUM_SEL = 2 ** SEL_W;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_DUMP = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic              accept;
    logic              emit_code;
    logic [STAT_W-1:0] code;
    logic              push;
    logic              pop_start;
    logic              dump_start;
    logic              emit_word;
  } pms_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            invalid;
    logic            full;
    logic            empty;
    logic            out_free;
    logic            word_last;
  } pms_stat_t;

endpackage

// ===== hdl/pms_ctrl.sv =====
`timescale 1ns / 1ps

module pms_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pms_pkg::pms_stat_t stat_i,
  output pms_pkg::pms_cmd_t  cmd_o
);
  import pms_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.op != OP_PUSH && stat_i.op != OP_POP && stat_i.op != OP_DUMP) begin
          // unused code: no result
          state_d = S_IDLE;
        end else if (stat_i.out_free) begin
          if (stat_i.invalid) begin
            cmd_o.emit_code = 1'b1;
            cmd_o.code      = ST_INVALID;
            state_d         = S_IDLE;
          end else if (stat_i.op == OP_PUSH) begin
            cmd_o.emit_code = 1'b1;
            cmd_o.code      = stat_i.full ? ST_FULL : ST_OK;
            cmd_o.push      = !stat_i.full;
            state_d         = S_IDLE;
          end else if (stat_i.empty) begin
            cmd_o.emit_code = 1'b1;
            cmd_o.code      = ST_EMPTY;
            state_d         = S_IDLE;
          end else begin
            cmd_o.pop_start  = (stat_i.op == OP_POP);
            cmd_o.dump_start = (stat_i.op == OP_DUMP);
            state_d          = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_word = 1'b1;
          if (stat_i.word_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/pms_datapath.sv =====
`timescale 1ns / 1ps

module pms_datapath #(
  parameter int unsigned STORE_DEPTH = 64,
  parameter int unsigned MAX_STACKS  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pms_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic [pms_pkg::OP_W-1:0]            operation_i,
  input  logic [pms_pkg::SEL_W-1:0]           stack_select_i,
  input  logic signed [pms_pkg::DATA_W-1:0]   push_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pms_pkg::STAT_W-1:0]          status_o,
  output logic signed [pms_pkg::DATA_W-1:0]   data_value_o,
  output logic                                last_o,
  input  pms_pkg::pms_cmd_t                   cmd_i,
  output pms_pkg::pms_stat_t                  stat_o
);
  import pms_pkg::*;

  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
  localparam int unsigned FILL_W = $clog2(STORE_DEPTH + 1);

  // partition size and last partition capacity, indexed by live count - 1
  logic [FILL_W-1:0] part_tbl [NUM_SEL];
  logic [FILL_W-1:0] lcap_tbl [NUM_SEL];

  for (genvar g = 0; g < NUM_SEL; g++) begin : g_tbl
    localparam int unsigned PartSize = STORE_DEPTH / (g + 1);
    assign part_tbl[g] = FILL_W'(PartSize);
    assign lcap_tbl[g] = FILL_W'(STORE_DEPTH - PartSize * g);
  end

  logic [CFG_W-1:0]  live_n;
  logic [SEL_W-1:0]  live_idx;
  logic [CFG_W-1:0]  n_q;
  logic [FILL_W-1:0] part_q;
  logic [FILL_W-1:0] lcap_q;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      live_n = CFG_W'(1);
    end else if (cfg_wdata_i > CFG_W'(MAX_STACKS)) begin
      live_n = CFG_W'(MAX_STACKS);
    end else begin
      live_n = cfg_wdata_i;
    end
  end

  assign live_idx = SEL_W'(live_n - CFG_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= CFG_W'(1);
      part_q <= FILL_W'(STORE_DEPTH);
      lcap_q <= FILL_W'(STORE_DEPTH);
    end else if (cfg_we_i) begin
      n_q    <= live_n;
      part_q <= part_tbl[live_idx];
      lcap_q <= lcap_tbl[live_idx];
    end
  end

  // latched item and its stack geometry
  logic [OP_W-1:0]          op_q;
  logic [SEL_W-1:0]         sel_q;
  logic [DATA_W-1:0]        value_q;
  logic [FILL_W-1:0]        base_q;
  logic [FILL_W-1:0]        cap_q;
  logic [FILL_W-1:0]        fill_q;
  logic                     invalid_q;
  logic [FILL_W-1:0]        cnt_q;
  logic [FILL_W-1:0]        fill_mem [NUM_SEL];
  logic [FILL_W+SEL_W-1:0]  base_prod;
  logic                     sel_is_last;

  assign base_prod   = part_q * stack_select_i;
  assign sel_is_last = ({1'b0, stack_select_i} == (n_q - CFG_W'(1)));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q      <= operation_i;
      sel_q     <= stack_select_i;
      value_q   <= push_value_i;
      base_q    <= FILL_W'(base_prod);
      cap_q     <= sel_is_last ? lcap_q : part_q;
      fill_q    <= fill_mem[stack_select_i];
      invalid_q <= ({1'b0, stack_select_i} >= n_q);
    end
  end

  logic word_last;
  logic is_full;
  logic rd_en;
  logic [FILL_W:0]   top_sum;
  logic [FILL_W:0]   rd_sum;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign word_last = (op_q == OP_POP) || (cnt_q == fill_q);
  assign is_full   = (fill_q >= cap_q);
  assign top_sum   = {1'b0, base_q} + {1'b0, fill_q};
  assign wr_addr   = ADDR_W'(top_sum);

  always_comb begin
    if (cmd_i.pop_start) begin
      rd_sum = top_sum - (FILL_W + 1)'(1);
    end else if (cmd_i.dump_start) begin
      rd_sum = {1'b0, base_q};
    end else begin
      rd_sum = {1'b0, base_q} + {1'b0, cnt_q};
    end
  end

  assign rd_addr = ADDR_W'(rd_sum);
  assign rd_en   = cmd_i.pop_start || cmd_i.dump_start || (cmd_i.emit_word && !word_last);

  // word position of the next dump read
  always_ff @(posedge clk_i) begin
    if (cmd_i.dump_start) begin
      cnt_q <= FILL_W'(1);
    end else if (cmd_i.emit_word && !word_last) begin
      cnt_q <= cnt_q + FILL_W'(1);
    end
  end

  // fill counters, a config write clears them all
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SEL; i++) begin
        fill_mem[i] <= '0;
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < NUM_SEL; i++) begin
        fill_mem[i] <= '0;
      end
    end else if (cmd_i.push) begin
      fill_mem[sel_q] <= fill_q + FILL_W'(1);
    end else if (cmd_i.pop_start) begin
      fill_mem[sel_q] <= fill_q - FILL_W'(1);
    end
  end

  // shared word store
  logic [DATA_W-1:0] store_mem [STORE_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      store_mem[wr_addr] <= value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= store_mem[rd_addr];
    end
  end

  // output register
  logic                     out_valid_q;
  logic [STAT_W-1:0]        status_q;
  logic signed [DATA_W-1:0] data_q;
  logic                     last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_code || cmd_i.emit_word) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_code) begin
      status_q <= cmd_i.code;
      data_q   <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.emit_word) begin
      status_q <= ST_OK;
      data_q   <= $signed(rdata_q);
      last_q   <= word_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign data_value_o = data_q;
  assign last_o       = last_q;

  assign stat_o.op        = op_q;
  assign stat_o.invalid   = invalid_q;
  assign stat_o.full      = is_full;
  assign stat_o.empty     = (fill_q == '0);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.word_last = word_last;

`ifndef NO_ASSERTIONS
  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_code || cmd_i.emit_word) |-> (!out_valid_q || out_ready_i))
    else $error("result written over one not yet transferred");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (!is_full && !invalid_q))
    else $error("push into a full or invalid stack");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop_start || cmd_i.dump_start) |-> (fill_q != '0))
    else $error("read started on an empty stack");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (fill_mem[0] == '0))
    else $error("fill count not cleared by config write");
`endif

endmodule

// ===== hdl/partitioned_multi_stack_top.sv =====
`timescale 1ns / 1ps

// channel | signals                                         | direction
// config  | cfg_we_i, cfg_wdata_i                           | in, write only
// items   | in_valid_i/in_ready_o, operation_i,             | in
//         |   stack_select_i, push_value_i                  |
// results | out_valid_o/out_ready_i, status_o,              | out
//         |   data_value_o, last_o                          |
//
// push, full, empty, invalid: accept, then evaluate and write the result code
// pop: accept, evaluate and start the registered store read, then emit the word
// dump of n words: one word per cycle once the first read returns, while the output is free
// async reset empties all stacks and sets the count to one; no clearing pass
// a result waits in the output register while the next item is taken in
module partitioned_multi_stack_top #(
  parameter int unsigned STORE_DEPTH = 64,
  parameter int unsigned MAX_STACKS  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pms_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pms_pkg::OP_W-1:0]          operation_i,
  input  logic [pms_pkg::SEL_W-1:0]         stack_select_i,
  input  logic signed [pms_pkg::DATA_W-1:0] push_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pms_pkg::STAT_W-1:0]        status_o,
  output logic signed [pms_pkg::DATA_W-1:0] data_value_o,
  output logic                              last_o
);
  import pms_pkg::*;

  // command and status between sequencer and datapath
  pms_cmd_t  cmd;
  pms_stat_t stat;

  // sequencer: accept, evaluate, then stream popped or dumped words
  pms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: geometry tables, fill counters, shared store, output register
  pms_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_STACKS  (MAX_STACKS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (operation_i),
    .stack_select_i (stack_select_i),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .data_value_o   (data_value_o),
    .last_o         (last_o),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule

// ===== test/pms_checker.sv =====
`timescale 1ns / 1ps

module pms_checker #(
  parameter int unsigned STORE_DEPTH = 64,
  parameter int unsigned MAX_STACKS  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pms_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [pms_pkg::OP_W-1:0]          operation_i,
  input  logic [pms_pkg::SEL_W-1:0]         stack_select_i,
  input  logic signed [pms_pkg::DATA_W-1:0] push_value_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [pms_pkg::STAT_W-1:0]        status_i,
  input  logic signed [pms_pkg::DATA_W-1:0] data_value_i,
  input  logic                              last_i,
  output int                                error_count_o,
  output int                                pending_o,
  output int                                checked_o
);
  import pms_pkg::*;

  // watches the config port and both channels, keeps its own copy of the stacks
  // and compares every result transfer with the oldest predicted one

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;
    logic              last;
  } stack_result_t;

  stack_result_t     expected_results[$];
  logic [DATA_W-1:0] shared_words[STORE_DEPTH];
  int unsigned       stack_fill[NUM_SEL];
  logic [CFG_W-1:0]  count_reg;
  stack_result_t     want;
  stack_result_t     got;
  int                mismatches   = 0;
  int                results_seen = 0;
  int                pending_count = 0;

  assign error_count_o = mismatches;
  assign pending_o     = pending_count;
  assign checked_o     = results_seen;

  function automatic void queue_result(logic [STAT_W-1:0] status, logic [DATA_W-1:0] data,
                                       logic last);
    stack_result_t r;
    r.status = status;
    r.data   = data;
    r.last   = last;
    expected_results.push_back(r);
  endfunction

  task automatic predict_stack_op(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel,
                                  input logic [DATA_W-1:0] word);
    int unsigned live;
    int unsigned part;
    int unsigned base;
    int unsigned cap;
    int unsigned fill;
    live = (count_reg == 0) ? 1 : (count_reg > MAX_STACKS) ? MAX_STACKS : count_reg;
    if (op != OP_PUSH && op != OP_POP && op != OP_DUMP) return;
    if (sel >= live) begin
      queue_result(ST_INVALID, '0, 1'b1);
      return;
    end
    part = STORE_DEPTH / live;
    base = part * sel;
    cap  = (sel == live - 1) ? STORE_DEPTH - part * (live - 1) : part;
    fill = stack_fill[sel];
    if (op == OP_PUSH) begin
      if (fill >= cap) begin
        queue_result(ST_FULL, '0, 1'b1);
      end else begin
        shared_words[(base + fill) % STORE_DEPTH] = word;
        stack_fill[sel] = fill + 1;
        queue_result(ST_OK, '0, 1'b1);
      end
    end else if (fill == 0) begin
      queue_result(ST_EMPTY, '0, 1'b1);
    end else if (op == OP_POP) begin
      stack_fill[sel] = fill - 1;
      queue_result(ST_OK, shared_words[(base + fill - 1) % STORE_DEPTH], 1'b1);
    end else begin
      // dump runs bottom to top, last only on the top word
      for (int unsigned k = 0; k < fill; k++) begin
        queue_result(ST_OK, shared_words[(base + k) % STORE_DEPTH], k + 1 == fill);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      foreach (shared_words[i]) shared_words[i] = '0;
      foreach (stack_fill[i]) stack_fill[i] = 0;
      count_reg     = 6'd1;
      pending_count = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.status = status_i;
        got.data   = data_value_i;
        got.last   = last_i;
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d data %0d last %0d",
                   $time, got.status, $signed(got.data), got.last);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, got.status);
            mismatches++;
          end
          if (got.data !== want.data) begin
            $display("%0t: data_value mismatch, expected %0d actual %0d",
                     $time, $signed(want.data), $signed(got.data));
            mismatches++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last mismatch, expected %0d actual %0d",
                     $time, want.last, got.last);
            mismatches++;
          end
        end
      end
      // any write of the count empties every stack
      if (cfg_we_i) begin
        count_reg = cfg_wdata_i;
        foreach (stack_fill[i]) stack_fill[i] = 0;
      end
      if (in_valid_i && in_ready_i) begin
        predict_stack_op(operation_i, stack_select_i, push_value_i);
      end
      pending_count = expected_results.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import pms_pkg::*;

  localparam int unsigned MAX_STACKS  = 32;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          HOLD_CYCLES = 80;
  // operation code the block must ignore without any result
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_we_i       = 1'b0;
  logic [CFG_W-1:0]         cfg_wdata_i    = '0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic [OP_W-1:0]          operation_i    = OP_PUSH;
  logic [SEL_W-1:0]         stack_select_i = '0;
  logic signed [DATA_W-1:0] push_value_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic [STAT_W-1:0]        status_o;
  logic signed [DATA_W-1:0] data_value_o;
  logic                     last_o;

  int failures;
  int pending;
  int checked;

  // sender pacing state
  int          burst_left       = 0;
  bit          steady           = 1'b0;
  int          items_sent       = 0;
  int          settings_written = 0;
  int unsigned live_stacks      = 1;

  // receiver stall state, owned by the receiver process
  logic        hold_req     = 1'b0;
  bit          hold_done    = 1'b0;
  int          hold_left    = 0;
  int          pattern_age  = 0;
  logic [7:0]  stall_pattern = 8'hff;
  logic [2:0]  pattern_pos  = '0;
  int          cycle_count  = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  partitioned_multi_stack_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .stack_select_i (stack_select_i),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .data_value_o   (data_value_o),
    .last_o         (last_o)
  );

  pms_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .operation_i    (operation_i),
    .stack_select_i (stack_select_i),
    .push_value_i   (push_value_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status_o),
    .data_value_i   (data_value_o),
    .last_i         (last_o),
    .error_count_o  (failures),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  // receiver: one long hold-off on request, otherwise a rotating stall pattern
  // that is swapped at random, sometimes for a no-stall stretch
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready_i <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        pattern_age = $urandom_range(20, 60);
        // bit 0 forced high so every pass through the pattern has at least one ready
        stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom() | 32'h1);
      end
      pattern_age--;
      out_ready_i <= stall_pattern[pattern_pos];
      pattern_pos = pattern_pos + 1'b1;
    end
  end

  // watchdog, covers the slowest legal run several times over
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
      $display("FAIL partitioned_multi_stack_top");
      $finish;
    end
  end

  // offer one item and hold it until the transfer, then maybe open a gap
  task automatic send_item(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel,
                           input logic [DATA_W-1:0] word);
    logic taken;
    int   gap;
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    stack_select_i <= sel;
    push_value_i   <= word;
    // ready is stable between the falling and the next rising edge
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (!steady) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 30 : $urandom_range(1, 12);
    end
  endtask

  // sender goes quiet until every result is back, plus room for ignored items
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // only called while idle; out-of-range counts clamp in the block
  task automatic write_count(input logic [CFG_W-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_written++;
    live_stacks = (value == 0) ? 1 : (value > MAX_STACKS) ? MAX_STACKS : value;
  endtask

  initial begin
    int unsigned       phase_counts[8];
    int                push_pct;
    int                r;
    logic [OP_W-1:0]   op;
    logic [SEL_W-1:0]  sel;
    logic [DATA_W-1:0] word;

    phase_counts = '{5, 2, 32, 1, 33, 3, 0, 17};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one stack over the whole store after reset
    send_item(OP_PUSH, 5'd0, 32'h7fffffff);
    send_item(OP_PUSH, 5'd0, 32'h80000000);
    send_item(OP_POP, 5'd0, 32'h0);
    send_item(OP_DUMP, 5'd0, 32'hffffffff);
    send_item(OP_POP, 5'd0, 32'h0);
    send_item(OP_POP, 5'd0, 32'h0);          // pop on empty stack
    send_item(OP_DUMP, 5'd0, 32'h0);         // dump of empty stack
    send_item(OP_PUSH, 5'd31, 32'h12345678); // stack number out of range
    send_item(OP_UNUSED, 5'd0, 32'h0);       // ignored, no result

    // most partitions, two words each
    settle();
    write_count(6'd32);
    send_item(OP_PUSH, 5'd31, 32'h00000001);
    send_item(OP_PUSH, 5'd31, 32'hfffffffe);
    send_item(OP_PUSH, 5'd31, 32'h55555555); // partition full
    send_item(OP_DUMP, 5'd31, 32'h0);
    send_item(OP_PUSH, 5'd0, 32'hffffffff);
    send_item(OP_POP, 5'd0, 32'h0);
    send_item(OP_POP, 5'd0, 32'h0);
    send_item(OP_PUSH, 5'd0, 32'h0);

    // zero acts as one stack, and rewriting empties everything
    settle();
    write_count(6'd0);
    send_item(OP_POP, 5'd0, 32'h0);
    send_item(OP_DUMP, 5'd1, 32'h0);

    // all ones clamps to the stack limit
    settle();
    write_count(6'd63);
    send_item(OP_PUSH, 5'd31, 32'haaaaaaaa);
    send_item(OP_DUMP, 5'd31, 32'h0);

    // random phases, each under a new stack count with its own push bias
    foreach (phase_counts[p]) begin
      settle();
      write_count(CFG_W'(phase_counts[p]));
      push_pct = $urandom_range(40, 85);
      // one phase runs gap-free into a long receiver hold-off so the input backs up
      steady = (p == 2);
      if (p == 2) hold_req <= 1'b1;
      repeat (12) begin
        r = $urandom_range(0, 99);
        if (r < push_pct) op = OP_PUSH;
        else if (r < 96) op = (r % 3 == 0) ? OP_DUMP : OP_POP;
        else op = OP_UNUSED;
        sel = ($urandom_range(0, 9) == 0) ? SEL_W'($urandom()) :
                                            SEL_W'($urandom_range(0, live_stacks - 1));
        if ($urandom_range(0, 7) == 0) word = $urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff;
        else word = $urandom();
        send_item(op, sel, word);
      end
    end

    settle();
    repeat (20) @(negedge clk_i);
    $display("covered %0d items under %0d stack-count settings, %0d results checked",
             items_sent, settings_written, checked);
    $display("full, empty, invalid and ignored items, dumps, and a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (failures == 0 && pending == 0) begin
      $display("PASS partitioned_multi_stack_top");
    end else begin
      $display("FAIL partitioned_multi_stack_top");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pms_pkg.sv
hdl/pms_ctrl.sv
hdl/pms_datapath.sv
hdl/partitioned_multi_stack_top.sv
test/pms_checker.sv
test/tb_top.sv
